// ===== rtl/tmce_pkg.sv =====
// ----------------------------------------------------------------------------
// tmce_pkg
// Shared constants, types and helpers for the text mode console engine.
// ----------------------------------------------------------------------------
package tmce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COPY_N  = (ROWS - 1) * COLUMNS;   // cells moved by a scroll
  localparam int FILL_BASE = (ROWS - 1) * COLUMNS; // first cell of bottom row

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_POS  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_COLOR  = 8'd7;

  // controller -> datapath
  typedef struct packed {
    logic latch;    // capture request fields
    logic exec;     // perform the single cell access and cursor update
    logic copy;     // scroll copy step
    logic fill;     // bottom row blank fill step
    logic clear;    // post-reset clearing step
    logic cnt_clr;  // restart the sweep counter
    logic emit;     // load the result registers and pulse the strobe
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic copy_last;
    logic fill_last;
    logic need_scroll;
    logic need_read;
  } stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(row);
    return ADDR_W'(r * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  endfunction

endpackage

// ===== rtl/tmce_ram.sv =====
// ----------------------------------------------------------------------------
// tmce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tmce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/tmce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmce_ctrl
// Sequencer: post-reset clear, single access, read wait, scroll copy, fill.
// ----------------------------------------------------------------------------
module tmce_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  tmce_pkg::stat_t stat,
  output tmce_pkg::cmd_t  cmd
);
  import tmce_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_scroll) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_COPY;
        end else if (stat.need_read) begin
          state_nxt = S_READ;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.copy_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.fill_last) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_copy_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && stat.copy_last) |=> (state_r == S_FILL))
    else $error("scroll copy did not move on to fill");

  a_no_emit_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !cmd.emit)
    else $error("result emitted during clearing pass");

endmodule

// ===== rtl/tmce_dp.sv =====
// ----------------------------------------------------------------------------
// tmce_dp
// Datapath: request capture, cursor, color register, screen RAM, sweep
// counter and result registers.
// ----------------------------------------------------------------------------
module tmce_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmce_pkg::cmd_t                cmd,
  output tmce_pkg::stat_t               stat,
  input  logic [tmce_pkg::OP_W-1:0]     in_operation,
  input  logic [tmce_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tmce_pkg::ATTR_W-1:0]   in_color_attr,
  input  logic [tmce_pkg::COL_W-1:0]    in_col_pos,
  input  logic [tmce_pkg::ROW_W-1:0]    in_row_pos,
  input  logic                          cfg_we,
  input  logic [tmce_pkg::ATTR_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  output logic [tmce_pkg::CELL_W-1:0]   out_cell_entry,
  output logic [tmce_pkg::ROW_W-1:0]    out_cursor_row,
  output logic [tmce_pkg::COL_W-1:0]    out_cursor_col
);
  import tmce_pkg::*;

  // captured request
  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;

  logic [ATTR_W-1:0] color_r;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0] cnt_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  logic              in_range, rd_ok, advance, at_last_col, at_last_row;
  logic [ADDR_W-1:0] pos_addr, cur_addr;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign in_range    = (col_r < COL_W'(COLUMNS)) && (row_r < ROW_W'(ROWS));
  assign rd_ok       = (op_r == OP_READ) && in_range;
  assign pos_addr    = cell_addr(row_r, col_r);
  assign cur_addr    = cell_addr(cur_row_r, cur_col_r);
  assign at_last_col = (cur_col_r == COL_W'(COLUMNS - 1));
  assign at_last_row = (cur_row_r == ROW_W'(ROWS - 1));
  assign advance     = (ch_r == NEWLINE_CODE) || at_last_col;

  assign stat.clr_last    = (cnt_r == ADDR_W'(CELLS - 1));
  assign stat.copy_last   = (cnt_r == ADDR_W'(COPY_N));
  assign stat.fill_last   = (cnt_r == ADDR_W'(COLUMNS - 1));
  assign stat.need_scroll = (op_r == OP_PUT) && advance && at_last_row;
  assign stat.need_read   = rd_ok;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_operation;
      ch_r   <= in_char_code;
      attr_r <= in_color_attr;
      col_r  <= in_col_pos;
      row_r  <= in_row_pos;
    end
  end

  // cursor: only a cursor write moves it; the row saturates at the bottom
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (cmd.exec && op_r == OP_PUT) begin
      if (advance) begin
        cur_col_nxt = '0;
        if (!at_last_row) begin
          cur_row_nxt = cur_row_r + 1'b1;
        end
      end else begin
        cur_col_nxt = cur_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r     <= RESET_COLOR;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.clear || cmd.copy || cmd.fill) begin
        cnt_r <= cnt_r + 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cell_r <= rd_ok ? ram_rdata : '0;
      out_row_r  <= cur_row_nxt;
      out_col_r  <= cur_col_nxt;
    end
  end

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_r;
    ram_raddr = pos_addr;
    ram_wdata = {RESET_COLOR, BLANK_CODE};
    if (cmd.clear) begin
      ram_we = 1'b1;
    end else if (cmd.copy) begin
      // read one row below, write the word read last cycle one cell back
      ram_re    = (cnt_r < ADDR_W'(COPY_N));
      ram_raddr = cnt_r + ADDR_W'(COLUMNS);
      ram_we    = (cnt_r != '0);
      ram_waddr = cnt_r - 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.fill) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(FILL_BASE) + cnt_r;
      ram_wdata = {color_r, BLANK_CODE};
    end else if (cmd.exec) begin
      case (op_r)
        OP_PUT: begin
          ram_we    = (ch_r != NEWLINE_CODE);
          ram_waddr = cur_addr;
          ram_wdata = {color_r, ch_r};
        end
        OP_POS: begin
          ram_we    = in_range;
          ram_waddr = pos_addr;
          ram_wdata = {attr_r, ch_r};
        end
        OP_READ: begin
          ram_re = in_range;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  tmce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_cell_entry = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr < ADDR_W'(CELLS)))
    else $error("RAM write outside the screen");

  a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (ram_raddr < ADDR_W'(CELLS)))
    else $error("RAM read outside the screen");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r < ROW_W'(ROWS)) && (cur_col_r < COL_W'(COLUMNS)))
    else $error("cursor left the screen");

endmodule

// ===== rtl/text_mode_console_engine.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_engine
// Character cell console: 80x25 screen store with cursor and scrolling.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_* and raise start; the request is taken on a
//   rising edge where start is high and busy is low.
//   Result channel: out_valid pulses for one cycle with out_cell_entry,
//   out_cursor_row and out_cursor_col. There is no backpressure; the
//   receiver must take the result in that cycle.
//   Config: cfg_we with cfg_wdata loads the text color (reset 7). Write only
//   while idle.
// Sequence:
//   Cursor writes and positioned writes: the accept edge moves the sequencer
//   to its execute state, which loads the registered strobe; busy is high until then.
//   In-range cell reads add a read wait state for the registered RAM read.
//   A cursor write that runs off the bottom row scrolls: a copy pass moves the
//   rows up, one cell per cycle through the single RAM port pair, then a
//   blank fill writes the bottom row before the strobe is loaded.
// Reset:
//   rst_n is synchronous, active low. Cursor goes to 0,0, color to 7, and a
//   clearing pass writes blank cells to all 2000 entries, one per cycle;
//   busy stays high until the pass ends. Config writes are still taken.
// ----------------------------------------------------------------------------
module text_mode_console_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tmce_pkg::OP_W-1:0]   in_operation,
  input  logic [tmce_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tmce_pkg::ATTR_W-1:0] in_color_attr,
  input  logic [tmce_pkg::COL_W-1:0]  in_col_pos,
  input  logic [tmce_pkg::ROW_W-1:0]  in_row_pos,
  output logic                        out_valid,
  output logic [tmce_pkg::CELL_W-1:0] out_cell_entry,
  output logic [tmce_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tmce_pkg::COL_W-1:0]  out_cursor_col,
  input  logic                        cfg_we,
  input  logic [tmce_pkg::ATTR_W-1:0] cfg_wdata
);
  import tmce_pkg::*;

  cmd_t  cmd;   // sequencer commands
  stat_t stat;  // datapath status back to the sequencer

  tmce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tmce_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_operation),
    .in_char_code   (in_char_code),
    .in_color_attr  (in_color_attr),
    .in_col_pos     (in_col_pos),
    .in_row_pos     (in_row_pos),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_cell_entry (out_cell_entry),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col)
  );

endmodule

// ===== dv/tb_text_mode_console_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_mode_console_engine
// Self-checking bench for the 80x25 character cell console. A cycle-free
// shadow of the screen store, cursor and text color predicts each result.
// Directed requests hit the field extremes and the corner cases. Random text
// runs then force line wraps and scrolls under several text colors, mixed
// with positioned writes and reads. Requests go out in bursts with gaps.
// ----------------------------------------------------------------------------
module tb_text_mode_console_engine;
  import tmce_pkg::*;

  // Operation code 3 is not used by the block: it must leave all state alone.
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int ITEMS_PER_PHASE = 140;

  typedef struct packed {
    logic [CELL_W-1:0] entry;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_result_t;

  // --------------------------------------------------------------------------
  // Shadow of the console state plus the FIFO of results still owed.
  // --------------------------------------------------------------------------
  class console_shadow;
    logic [CELL_W-1:0] cells [CELLS];
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [ATTR_W-1:0] color;
    console_result_t   pending_results [$];
    int                mismatch_count;

    function new();
      foreach (cells[i]) cells[i] = {RESET_COLOR, BLANK_CODE};
      cur_row = '0;
      cur_col = '0;
      color = RESET_COLOR;
      mismatch_count = 0;
    endfunction

    function void set_color(logic [ATTR_W-1:0] value);
      color = value;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Cursor to column 0 of the next row; off the bottom, shift the screen
    // up one row and blank the bottom row in the current text color.
    function void next_row();
      cur_col = '0;
      if (cur_row == ROW_W'(ROWS - 1)) begin
        for (int i = 0; i < COPY_N; i++) cells[i] = cells[i + COLUMNS];
        for (int i = FILL_BASE; i < CELLS; i++) cells[i] = {color, BLANK_CODE};
      end else begin
        cur_row++;
      end
    endfunction

    function void apply_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                logic [ATTR_W-1:0] attr, logic [COL_W-1:0] col,
                                logic [ROW_W-1:0] row);
      console_result_t res;
      bit in_range;
      int idx;
      in_range = (int'(col) < COLUMNS) && (int'(row) < ROWS);
      idx = int'(row) * COLUMNS + int'(col);
      res.entry = '0;
      case (op)
        OP_PUT: begin
          if (ch == NEWLINE_CODE) begin
            next_row();
          end else begin
            cells[int'(cur_row) * COLUMNS + int'(cur_col)] = {color, ch};
            if (cur_col == COL_W'(COLUMNS - 1)) next_row();
            else cur_col++;
          end
        end
        OP_POS: begin
          if (in_range) cells[idx] = {attr, ch};
        end
        OP_READ: begin
          if (in_range) res.entry = cells[idx];
        end
        default: ;
      endcase
      res.row = cur_row;
      res.col = cur_col;
      pending_results.push_back(res);
    endfunction

    function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [CELL_W-1:0] entry, logic [ROW_W-1:0] row,
                               logic [COL_W-1:0] col);
      console_result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h/%0d/%0d",
                 $time, entry, row, col);
        return;
      end
      exp_r = pending_results.pop_front();
      check_field("cell_entry", 16'(exp_r.entry), 16'(entry));
      check_field("cursor_row", 16'(exp_r.row), 16'(row));
      check_field("cursor_col", 16'(exp_r.col), 16'(col));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = OP_PUT;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [ATTR_W-1:0] in_color_attr = '0;
  logic [COL_W-1:0]  in_col_pos = '0;
  logic [ROW_W-1:0]  in_row_pos = '0;
  logic              out_valid;
  logic [CELL_W-1:0] out_cell_entry;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic              cfg_we = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata = '0;

  console_shadow shadow = new();
  int items_sent = 0;
  int burst_left = 0;

  text_mode_console_engine u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_char_code   (in_char_code),
    .in_color_attr  (in_color_attr),
    .in_col_pos     (in_col_pos),
    .in_row_pos     (in_row_pos),
    .out_valid      (out_valid),
    .out_cell_entry (out_cell_entry),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Monitor: all values are read before this edge's updates land, so a
  // request taken here and a strobe ending here are seen as the block saw
  // them. The strobe for a request taken at this edge comes later at the
  // earliest, so the order of the two calls does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) shadow.check_result(out_cell_entry, out_cursor_row, out_cursor_col);
      if (start && !busy)
        shadow.apply_request(in_operation, in_char_code, in_color_attr, in_col_pos,
                             in_row_pos);
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Called in the step of a rising edge; returns in the step
  // of the edge that took the request. start stays high across back-to-back
  // requests and drops only when a burst ends and a gap follows.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [ATTR_W-1:0] attr, input logic [COL_W-1:0] col,
                              input logic [ROW_W-1:0] row);
    in_operation  <= op;
    in_char_code  <= ch;
    in_color_attr <= attr;
    in_col_pos    <= col;
    in_row_pos    <= row;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 12);
    end
  endtask

  // Drain every owed result with start low, then load a new text color.
  task automatic write_text_color(input logic [ATTR_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (shadow.outstanding() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.set_color(value);
  endtask

  // Cursor writes; nl_pct percent of them are newlines. Unused fields random.
  task automatic type_text(input int n, input int nl_pct);
    logic [CHAR_W-1:0] ch;
    for (int i = 0; i < n; i++) begin
      ch = ($urandom_range(0, 99) < nl_pct) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
      send_request(OP_PUT, ch, ATTR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
    end
  endtask

  task automatic random_item();
    int pick;
    int sel;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pick = $urandom_range(0, 99);
    // position: in range mostly, anywhere in the field width sometimes
    if ($urandom_range(0, 9) == 0) begin
      col = COL_W'($urandom_range(0, 127));
      row = ROW_W'($urandom_range(0, 31));
    end else begin
      col = COL_W'($urandom_range(0, COLUMNS - 1));
      row = ROW_W'($urandom_range(0, ROWS - 1));
    end
    if (pick < 45) begin
      type_text($urandom_range(1, 40), 6);
    end else if (pick < 50) begin
      type_text($urandom_range(70, 170), 0);    // long line: runs past the last column
    end else if (pick < 54) begin
      type_text($urandom_range(1, 30), 100);    // run of newlines: scrolls at the bottom
    end else if (pick < 72) begin
      send_request(OP_POS, CHAR_W'($urandom), ATTR_W'($urandom), col, row);
    end else if (pick < 96) begin
      // aim half the reads at rows a scroll just moved or filled
      sel = $urandom_range(0, 5);
      if (sel == 0) row = shadow.cur_row;
      else if (sel == 1) row = ROW_W'(ROWS - 1);
      else if (sel == 2) row = ROW_W'(ROWS - 2);
      send_request(OP_READ, CHAR_W'($urandom), ATTR_W'($urandom), col, row);
    end else begin
      send_request(OP_NOP, CHAR_W'($urandom), ATTR_W'($urandom), COL_W'($urandom),
                   ROW_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [ATTR_W-1:0] phase_colors [6];
    int target;
    int guard;
    phase_colors = '{8'h00, 8'hFF, 8'h1E, 8'hF0, ATTR_W'($urandom), RESET_COLOR};
    burst_left = $urandom_range(1, 12);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset contents, default color, field extremes, out of range
    // positions on both axes, the unused opcode.
    send_request(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(OP_PUT, 8'h41, 8'h00, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(OP_PUT, 8'h00, 8'hFF, 7'd127, 5'd31);
    send_request(OP_PUT, 8'hFF, 8'h00, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, 8'h00, 7'd2, 5'd0);
    send_request(OP_PUT, NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
    send_request(OP_POS, 8'hFF, 8'hFF, 7'd79, 5'd24);
    send_request(OP_READ, 8'h00, 8'h00, 7'd79, 5'd24);
    send_request(OP_POS, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(OP_READ, 8'hFF, 8'hFF, 7'd0, 5'd0);
    send_request(OP_POS, 8'h5A, 8'hA5, 7'd80, 5'd0);
    send_request(OP_POS, 8'h5A, 8'hA5, 7'd0, 5'd25);
    send_request(OP_POS, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_request(OP_READ, 8'h00, 8'h00, 7'd80, 5'd0);
    send_request(OP_READ, 8'h00, 8'h00, 7'd0, 5'd25);
    send_request(OP_READ, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_request(OP_READ, 8'h00, 8'h00, 7'd79, 5'd0);
    send_request(OP_NOP, 8'hFF, 8'hFF, 7'd127, 5'd31);
    send_request(OP_NOP, 8'h00, 8'h00, 7'd0, 5'd0);
    send_request(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);

    // Random phases, one text color each. The first opens with a full line
    // (wrap at the last column) and enough newlines to scroll four times.
    for (int p = 0; p < 6; p++) begin
      write_text_color(phase_colors[p]);
      if (p == 0) begin
        type_text(85, 0);
        type_text(26, 100);
      end
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_item();
    end

    // Wind down: wait for the owed results, then watch for any stray strobe.
    start <= 1'b0;
    guard = 0;
    while (shadow.outstanding() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (shadow.outstanding() != 0) begin
      shadow.mismatch_count += shadow.outstanding();
      $display("%0t: results missing, expected %0d more actual 0", $time,
               shadow.outstanding());
    end
    if (shadow.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop, far beyond even every request scrolling.
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
